/* sv/rtwf_pkg.sv */
// shared constants and types for the route time window feasibility checker
package rtwf_pkg;

    localparam int TIME_W = 20;
    localparam int T_EXT  = (TIME_W >= 20) ? TIME_W + 1 : 21;
    localparam int OUT_W  = 20;
    localparam int LOAD_W = 20;
    localparam int DIST_W = 28;
    localparam int CAP_W  = 16;
    localparam int RUN_W  = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [T_EXT-1:0]  TIME_MAX_X = T_EXT'((65'd1 << TIME_W) - 65'd1);
    localparam logic [LOAD_W-1:0] LOAD_MAX   = '1;
    localparam logic [DIST_W-1:0] DIST_MAX   = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN  = 1'b1;

    typedef enum logic [1:0] {
        FAIL_NONE = 2'd0,
        FAIL_LATE = 2'd1,
        FAIL_LOAD = 2'd2,
        FAIL_RUN  = 2'd3
    } t_fail_cause;

endpackage

/* sv/route_time_window_feasibility.sv */
// route time window feasibility checker, one station request per cycle while not stalled
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------
//  station  | in        | i_in_valid / o_in_stall      | travel, distance, window, load
//  result   | out       | o_out_valid / i_out_stall    | arrival, status, totals
//  config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  the result register is loaded at the edge the request is taken and the route state
//  updates at the same edge, so requests may follow every cycle while o_in_stall is low
//  o_in_stall is high only while a result is held and the output is stalled
//  synchronous active-low reset clears the route state; limits reset to their maximum
//  config writes are always ready
module route_time_window_feasibility
    import rtwf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [11:0]           i_travel_minutes,
    input  logic [15:0]           i_distance_q8,
    input  logic [15:0]           i_earliest_minutes,
    input  logic [15:0]           i_latest_minutes,
    input  logic [11:0]           i_demand,
    input  logic [11:0]           i_service_minutes,
    input  logic                  i_depot_stop,
    input  logic                  i_last_in_route,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_W-1:0]      o_arrival_minutes,
    output logic                  o_arrival_valid,
    output logic [1:0]            o_fail_cause,
    output logic                  o_route_done,
    output logic                  o_feasible,
    output logic [OUT_W-1:0]      o_travel_sum_minutes,
    output logic [OUT_W-1:0]      o_service_sum_minutes,
    output logic [OUT_W-1:0]      o_run_sum_minutes,
    output logic [OUT_W-1:0]      o_load_sum,
    output logic [DIST_W-1:0]     o_total_distance_q8,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [CAP_W-1:0]  r_capacity;
    logic [RUN_W-1:0]  r_max_run;

    // route state
    logic [TIME_W-1:0] r_clock,       n_clock;
    logic [LOAD_W-1:0] r_load_sum,    n_load_sum;
    logic [TIME_W-1:0] r_travel_sum,  n_travel_sum;
    logic [TIME_W-1:0] r_service_sum, n_service_sum;
    logic [DIST_W-1:0] r_dist_sum,    n_dist_sum;
    logic              r_at_start,    n_at_start;
    logic              r_failed,      n_failed;
    t_fail_cause       r_code,        n_code;

    // result register
    logic              r_out_valid,   n_out_valid;
    logic [OUT_W-1:0]  r_out_arrival, n_out_arrival;
    logic              r_out_avalid,  n_out_avalid;
    t_fail_cause       r_out_cause,   n_out_cause;
    logic              r_out_done,    n_out_done;
    logic              r_out_feas,    n_out_feas;
    logic [OUT_W-1:0]  r_out_travel,  n_out_travel;
    logic [OUT_W-1:0]  r_out_service, n_out_service;
    logic [OUT_W-1:0]  r_out_runtime, n_out_runtime;
    logic [OUT_W-1:0]  r_out_load,    n_out_load;
    logic [DIST_W-1:0] r_out_dist,    n_out_dist;

    logic              accept;
    logic [T_EXT-1:0]  t_travel, t_arr, arrival_x, trav_x, svc_x, clk_x, run_x;
    logic [LOAD_W:0]   ld_raw;
    logic [LOAD_W-1:0] ld_sat, ld;
    logic [DIST_W:0]   dist_raw;
    logic [TIME_W-1:0] travel_upd, service_upd, clock_upd, runtime;
    logic [DIST_W-1:0] dist_upd;
    logic              late, overload, passed, run_over;
    logic              fail_f;
    t_fail_cause       code_f;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        // arrival and window checks
        t_travel  = r_at_start ? T_EXT'(r_clock)
                               : T_EXT'(r_clock) + T_EXT'(i_travel_minutes);
        t_arr     = (t_travel < T_EXT'(i_earliest_minutes)) ? T_EXT'(i_earliest_minutes)
                                                            : t_travel;
        arrival_x = (t_arr > TIME_MAX_X) ? TIME_MAX_X : t_arr;
        late      = t_arr > T_EXT'(i_latest_minutes);

        // running travel and distance
        trav_x     = T_EXT'(r_travel_sum) + T_EXT'(i_travel_minutes);
        travel_upd = r_at_start ? r_travel_sum
                   : ((trav_x > TIME_MAX_X) ? TIME_W'(TIME_MAX_X) : TIME_W'(trav_x));
        dist_raw   = {1'b0, r_dist_sum} + (DIST_W + 1)'(i_distance_q8);
        dist_upd   = r_at_start ? r_dist_sum
                   : (dist_raw[DIST_W] ? DIST_MAX : dist_raw[DIST_W-1:0]);

        // load
        ld_raw   = {1'b0, r_load_sum} + (LOAD_W + 1)'(i_demand);
        ld_sat   = ld_raw[LOAD_W] ? LOAD_MAX : ld_raw[LOAD_W-1:0];
        ld       = i_depot_stop ? r_load_sum : ld_sat;
        overload = !i_depot_stop && (ld > LOAD_W'(r_capacity));

        // service and clock
        svc_x       = T_EXT'(r_service_sum) + T_EXT'(i_service_minutes);
        service_upd = (svc_x > TIME_MAX_X) ? TIME_W'(TIME_MAX_X) : TIME_W'(svc_x);
        clk_x       = arrival_x + T_EXT'(i_service_minutes);
        clock_upd   = (clk_x > TIME_MAX_X) ? TIME_W'(TIME_MAX_X) : TIME_W'(clk_x);

        passed = !r_failed && !late && !overload;

        // run limit on the last station
        run_x    = T_EXT'(travel_upd) + T_EXT'(service_upd);
        runtime  = (run_x > TIME_MAX_X) ? TIME_W'(TIME_MAX_X) : TIME_W'(run_x);
        run_over = T_EXT'(runtime) > T_EXT'(r_max_run);

        n_clock       = r_clock;
        n_load_sum    = r_load_sum;
        n_travel_sum  = r_travel_sum;
        n_service_sum = r_service_sum;
        n_dist_sum    = r_dist_sum;
        n_at_start    = r_at_start;
        fail_f        = r_failed;
        code_f        = r_code;

        if (!r_failed) begin
            n_travel_sum = travel_upd;
            n_dist_sum   = dist_upd;
            n_at_start   = 1'b0;
            if (late) begin
                fail_f = 1'b1;
                code_f = FAIL_LATE;
            end else begin
                n_load_sum = ld;
                if (overload) begin
                    fail_f = 1'b1;
                    code_f = FAIL_LOAD;
                end else begin
                    n_service_sum = service_upd;
                    n_clock       = clock_upd;
                end
            end
        end
        if (i_last_in_route && passed && run_over) begin
            fail_f = 1'b1;
            code_f = FAIL_RUN;
        end

        n_failed = fail_f;
        n_code   = code_f;

        // result
        n_out_arrival = r_failed ? '0 : OUT_W'(arrival_x);
        n_out_avalid  = !r_failed;
        n_out_cause   = code_f;
        n_out_done    = i_last_in_route;
        n_out_feas    = i_last_in_route && !fail_f;
        n_out_travel  = OUT_W'(n_travel_sum);
        n_out_service = OUT_W'(n_service_sum);
        n_out_runtime = (i_last_in_route && passed) ? OUT_W'(runtime) : '0;
        n_out_load    = (i_last_in_route && passed) ? OUT_W'(ld) : '0;
        n_out_dist    = n_dist_sum;

        // last station closes the route
        if (i_last_in_route) begin
            n_clock       = '0;
            n_load_sum    = '0;
            n_travel_sum  = '0;
            n_service_sum = '0;
            n_dist_sum    = '0;
            n_at_start    = 1'b1;
            n_failed      = 1'b0;
            n_code        = FAIL_NONE;
        end

        n_out_valid = accept ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= '1;
            r_max_run     <= '1;
            r_clock       <= '0;
            r_load_sum    <= '0;
            r_travel_sum  <= '0;
            r_service_sum <= '0;
            r_dist_sum    <= '0;
            r_at_start    <= 1'b1;
            r_failed      <= 1'b0;
            r_code        <= FAIL_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                    CFG_MAX_RUN:  r_max_run  <= i_cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_clock       <= n_clock;
                r_load_sum    <= n_load_sum;
                r_travel_sum  <= n_travel_sum;
                r_service_sum <= n_service_sum;
                r_dist_sum    <= n_dist_sum;
                r_at_start    <= n_at_start;
                r_failed      <= n_failed;
                r_code        <= n_code;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_arrival <= n_out_arrival;
            r_out_avalid  <= n_out_avalid;
            r_out_cause   <= n_out_cause;
            r_out_done    <= n_out_done;
            r_out_feas    <= n_out_feas;
            r_out_travel  <= n_out_travel;
            r_out_service <= n_out_service;
            r_out_runtime <= n_out_runtime;
            r_out_load    <= n_out_load;
            r_out_dist    <= n_out_dist;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_arrival_minutes     = r_out_arrival;
    assign o_arrival_valid       = r_out_avalid;
    assign o_fail_cause          = r_out_cause;
    assign o_route_done          = r_out_done;
    assign o_feasible            = r_out_feas;
    assign o_travel_sum_minutes  = r_out_travel;
    assign o_service_sum_minutes = r_out_service;
    assign o_run_sum_minutes     = r_out_runtime;
    assign o_load_sum            = r_out_load;
    assign o_total_distance_q8   = r_out_dist;

endmodule
